// ===== hdl/refcounted_lru_block_cache_assert.svh =====
// assertion macros shared by the buffer cache rtl
`ifndef REFCOUNTED_LRU_BLOCK_CACHE_ASSERT_SVH
`define REFCOUNTED_LRU_BLOCK_CACHE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RLBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rlbc_pkg.sv =====
// types and constants of the reference counted lru buffer cache
`timescale 1ns / 1ps
package rlbc_pkg;

   localparam int TAG_BITS   = 32;
   localparam int INDEX_BITS = 4;
   localparam int STAT_BITS  = 3;

   // request kinds
   typedef enum logic {
      REQ_ACQUIRE = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   // result status codes
   typedef enum logic [STAT_BITS-1:0] {
      STAT_HIT       = 3'd0,
      STAT_MISS      = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_RELEASED  = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   // control sequencer
   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // per cell update operation
   typedef enum logic [2:0] {
      OP_HOLD    = 3'd0,
      OP_INC     = 3'd1,
      OP_DEC     = 3'd2,
      OP_INSTALL = 3'd3,
      OP_SHIFT   = 3'd4,
      OP_TAIL    = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

   typedef struct packed {
      logic match;
      logic free;
   } cell_stat_type;

endpackage

// ===== hdl/rlbc_cell.sv =====
// one recency position of the cache: slot number, tag, valid mark and count
`timescale 1ns / 1ps
module rlbc_cell #(
   parameter int SLOT_BITS  = 4,
   parameter int REF_BITS   = 16,
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rlbc_pkg::cell_ctl_type       ctl,
   input  logic [rlbc_pkg::TAG_BITS-1:0] blk,
   input  logic [SLOT_BITS-1:0]         nxt_slot,
   input  logic [rlbc_pkg::TAG_BITS-1:0] nxt_tag,
   input  logic                         nxt_valid,
   input  logic [REF_BITS-1:0]          nxt_refs,
   input  logic [SLOT_BITS-1:0]         tail_slot,
   output logic [SLOT_BITS-1:0]         slot,
   output logic [rlbc_pkg::TAG_BITS-1:0] tag,
   output logic                         valid,
   output logic [REF_BITS-1:0]          refs,
   output rlbc_pkg::cell_stat_type      stat
);
   import rlbc_pkg::*;

   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic                 valid_ff, valid_in;
   logic [REF_BITS-1:0]  refs_ff, refs_in;

   // next entry for this position
   always_comb begin
      slot_in  = slot_ff;
      tag_in   = tag_ff;
      valid_in = valid_ff;
      refs_in  = refs_ff;
      unique case (ctl.op)
         OP_HOLD: begin
         end
         OP_INC: begin
            refs_in = refs_ff + REF_BITS'(1);
         end
         OP_DEC: begin
            refs_in = refs_ff - REF_BITS'(1);
         end
         OP_INSTALL: begin
            tag_in   = blk;
            valid_in = 1'b1;
            refs_in  = REF_BITS'(1);
         end
         OP_SHIFT: begin
            slot_in  = nxt_slot;
            tag_in   = nxt_tag;
            valid_in = nxt_valid;
            refs_in  = nxt_refs;
         end
         OP_TAIL: begin
            slot_in  = tail_slot;
            tag_in   = blk;
            valid_in = 1'b1;
            refs_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // control part of the entry
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= SLOT_BITS'(CELL_INDEX);
         valid_ff <= 1'b0;
         refs_ff  <= '0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
         refs_ff  <= refs_in;
      end
   end

   // tag is only looked at while valid
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign slot       = slot_ff;
   assign tag        = tag_ff;
   assign valid      = valid_ff;
   assign refs       = refs_ff;
   assign stat.match = valid_ff && (tag_ff == blk);
   assign stat.free  = (refs_ff == '0);

endmodule

// ===== hdl/refcounted_lru_block_cache.sv =====
// top level of the reference counted lru buffer cache (tags and counts)
//
// Input channel req_*: req_type selects acquire (0) or release (1) of block
// req_block_id. Result channel rsp_*: one word per request with status,
// slot index and the fetch flag that a miss install raises.
// Each request is registered in the accept cycle (state IDLE); in state EXEC
// the block compares the tag against every cell of the recency chain at
// once, picks the first free cell in order, updates the chosen cell and
// loads the result register, as soon as that register is empty or taken.
// The block takes no new request until the current one has updated the
// chain: one request is in the update stage at a time. A release that
// brings a count to zero shifts every later cell one place toward the head
// and puts the slot at the tail, in the same cycle.
// Reset (synchronous, active high) empties all slots and restores the order
// 0 to CACHE_SLOTS-1. If the receiver holds rsp_ready low, the result stays
// in its register, one more request may be taken and waits in the update
// stage; req_ready stays low until that result can be written.
`timescale 1ns / 1ps
`include "refcounted_lru_block_cache_assert.svh"
module refcounted_lru_block_cache #(
   parameter int CACHE_SLOTS = 16,
   parameter int REF_BITS    = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [rlbc_pkg::TAG_BITS-1:0]   req_block_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rlbc_pkg::STAT_BITS-1:0]  rsp_status,
   output logic [rlbc_pkg::INDEX_BITS-1:0] rsp_slot_index,
   output logic                            rsp_fetch_needed
);
   import rlbc_pkg::*;

   localparam int SLOT_BITS = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

   // sequencer and request registers
   fsm_type             state_ff, state_in;
   req_kind_type        kind_ff;
   logic [TAG_BITS-1:0] blk_ff;
   logic                accept;
   logic                do_exec;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic                  fetch_ff, fetch_in;

   // cell chain
   logic [SLOT_BITS-1:0] cell_slot  [CACHE_SLOTS];
   logic [TAG_BITS-1:0]  cell_tag   [CACHE_SLOTS];
   logic                 cell_valid [CACHE_SLOTS];
   logic [REF_BITS-1:0]  cell_refs  [CACHE_SLOTS];
   cell_stat_type        cell_stat  [CACHE_SLOTS];
   cell_ctl_type         cell_ctl   [CACHE_SLOTS];

   logic [CACHE_SLOTS-1:0] match_vec, free_vec, first_free_vec, sel_vec, after_vec;
   logic [CACHE_SLOTS:0]   match_seen, free_seen;
   logic                   any_match, any_free;
   logic [SLOT_BITS-1:0]   sel_slot;
   logic [REF_BITS-1:0]    sel_refs;
   logic                   hit_inc, do_install, do_dec, do_move;

   assign accept  = req_valid && req_ready;
   assign do_exec = (state_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (do_exec) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind_type'(req_type);
         blk_ff  <= req_block_id;
      end
   end

   assign match_seen[0] = 1'b0;
   assign free_seen[0]  = 1'b0;

   // cells and the per position search chains
   for (genvar g = 0; g < CACHE_SLOTS; g++) begin : gen_cell
      logic [SLOT_BITS-1:0] nxt_slot;
      logic [TAG_BITS-1:0]  nxt_tag;
      logic                 nxt_valid;
      logic [REF_BITS-1:0]  nxt_refs;

      if (g < CACHE_SLOTS - 1) begin : gen_link
         assign nxt_slot  = cell_slot[g+1];
         assign nxt_tag   = cell_tag[g+1];
         assign nxt_valid = cell_valid[g+1];
         assign nxt_refs  = cell_refs[g+1];
      end else begin : gen_end
         assign nxt_slot  = cell_slot[g];
         assign nxt_tag   = cell_tag[g];
         assign nxt_valid = cell_valid[g];
         assign nxt_refs  = cell_refs[g];
      end

      assign match_vec[g]      = cell_stat[g].match;
      assign free_vec[g]       = cell_stat[g].free;
      assign match_seen[g+1]   = match_seen[g] | match_vec[g];
      assign free_seen[g+1]    = free_seen[g] | free_vec[g];
      assign first_free_vec[g] = free_vec[g] & ~free_seen[g];
      assign after_vec[g]      = match_seen[g+1];

      // operation for this position
      always_comb begin
         cell_ctl[g].op = OP_HOLD;
         if (do_exec) begin
            if (hit_inc && match_vec[g]) begin
               cell_ctl[g].op = OP_INC;
            end else if (do_install && first_free_vec[g]) begin
               cell_ctl[g].op = OP_INSTALL;
            end else if (do_dec && match_vec[g]) begin
               cell_ctl[g].op = OP_DEC;
            end else if (do_move && after_vec[g]) begin
               cell_ctl[g].op = (g == CACHE_SLOTS - 1) ? OP_TAIL : OP_SHIFT;
            end
         end
      end

      rlbc_cell #(
         .SLOT_BITS  (SLOT_BITS),
         .REF_BITS   (REF_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl[g]),
         .blk       (blk_ff),
         .nxt_slot  (nxt_slot),
         .nxt_tag   (nxt_tag),
         .nxt_valid (nxt_valid),
         .nxt_refs  (nxt_refs),
         .tail_slot (sel_slot),
         .slot      (cell_slot[g]),
         .tag       (cell_tag[g]),
         .valid     (cell_valid[g]),
         .refs      (cell_refs[g]),
         .stat      (cell_stat[g])
      );
   end

   assign any_match = match_seen[CACHE_SLOTS];
   assign any_free  = free_seen[CACHE_SLOTS];
   assign sel_vec   = any_match ? match_vec : first_free_vec;

   // fields of the selected cell
   always_comb begin
      sel_slot = '0;
      sel_refs = '0;
      for (int p = 0; p < CACHE_SLOTS; p++) begin
         if (sel_vec[p]) begin
            sel_slot = sel_slot | cell_slot[p];
            sel_refs = sel_refs | cell_refs[p];
         end
      end
   end

   // low bits of the slot number for the result
   logic [INDEX_BITS-1:0] sel_index;
   if (SLOT_BITS >= INDEX_BITS) begin : gen_idx_trunc
      assign sel_index = sel_slot[INDEX_BITS-1:0];
   end else begin : gen_idx_ext
      assign sel_index = {{(INDEX_BITS - SLOT_BITS){1'b0}}, sel_slot};
   end

   // decision and result
   always_comb begin
      hit_inc    = 1'b0;
      do_install = 1'b0;
      do_dec     = 1'b0;
      do_move    = 1'b0;
      status_in  = STAT_FULL;
      index_in   = '0;
      fetch_in   = 1'b0;
      if (kind_ff == REQ_ACQUIRE) begin
         if (any_match) begin
            if (sel_refs != '1) begin
               hit_inc   = 1'b1;
               status_in = STAT_HIT;
               index_in  = sel_index;
            end
         end else if (any_free) begin
            do_install = 1'b1;
            status_in  = STAT_MISS;
            index_in   = sel_index;
            fetch_in   = 1'b1;
         end
      end else begin
         if (any_match) begin
            status_in = STAT_RELEASED;
            index_in  = sel_index;
            if (sel_refs == REF_BITS'(1)) begin
               do_move = 1'b1;
            end else if (sel_refs != '0) begin
               do_dec = 1'b1;
            end
         end else begin
            status_in = STAT_NOT_FOUND;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_exec) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         fetch_ff  <= fetch_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot_index   = index_ff;
   assign rsp_fetch_needed = fetch_ff;

   // checks
   `RLBC_ASSERT_NOW(a_unique_match, clock, reset, state_ff == FSM_EXEC, $onehot0(match_vec), "more than one cell holds the tag")
   `RLBC_ASSERT_NOW(a_fetch_on_miss, clock, reset, rsp_valid_ff, fetch_ff == (status_ff == STAT_MISS), "fetch flag without miss install")
   `RLBC_ASSERT_NOW(a_index_zero, clock, reset, rsp_valid_ff && (status_ff == STAT_FULL || status_ff == STAT_NOT_FOUND), index_ff == '0, "slot index set on a failed word")
   `RLBC_ASSERT_NEXT(a_exec_loads, clock, reset, do_exec, rsp_valid_ff && state_ff == FSM_IDLE, "update cycle left no result")

endmodule
